// File: rtl/core/vmpe_pkg.sv
package vmpe_pkg;

  localparam int COMP_W         = 6;
  localparam int SUM_W          = 33;
  localparam int CNT_W          = 16;
  localparam int ANG_W          = 16;
  localparam int KAP_W          = 18;
  localparam int COMPONENTS_DEF = 64;

  localparam logic [KAP_W-1:0] CAP_RESET       = 18'd153600;
  localparam logic [29:0]      TWO_OVER_PI_Q30 = 30'd683565276;

  localparam int MUL_STEPS  = 33;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int STEP_W     = 6;

  typedef struct packed {
    logic [ANG_W-1:0] mean;
    logic [KAP_W-1:0] conc;
  } tbl_entry_t;

  typedef struct packed {
    logic              en;
    logic [COMP_W-1:0] comp;
    tbl_entry_t        entry;
  } tbl_wr_t;

  typedef enum logic [1:0] {
    AOP_MUL,
    AOP_DIV,
    AOP_SQRT
  } aop_t;

  typedef enum logic [3:0] {
    U_AXX,
    U_AYY,
    U_DD,
    U_SQRT,
    U_RHO,
    U_R2,
    U_LNUM,
    U_LDIV,
    U_UDEN,
    U_UDIV,
    U_T,
    U_T2,
    U_HORN,
    U_PT,
    U_ANG
  } uop_t;

  typedef enum logic [1:0] {
    RES_LOAD,
    RES_KEEP,
    RES_EST
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ISSUE,
    ST_WAIT,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       start;
    logic       retire;
    uop_t       uop;
    logic [1:0] horn_idx;
    logic       publish;
    res_t       res;
  } dp_cmd_t;

  typedef struct packed {
    logic load;
    logic invalid;
    logic force_one;
    logic lower;
    logic arith_done;
    logic out_free;
  } dp_stat_t;

  // odd atan polynomial, Q30, highest power first
  function automatic logic [31:0] atan_coef(input logic [2:0] k);
    logic [31:0] c;
    case (k)
      3'd0:    c = 32'(22371518);
      3'd1:    c = 32'(-91410863);
      3'd2:    c = 32'(193424926);
      3'd3:    c = 32'(-354656388);
      3'd4:    c = 32'(1073597943);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/vmpe_arith.sv
module vmpe_arith
  import vmpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  aop_t        op,
  input  logic [63:0] opa,
  input  logic [47:0] opb,
  output logic        done,
  output logic [63:0] result
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  aop_t              op_r, op_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [63:0]       x_r, x_nxt;
  logic [47:0]       y_r, y_nxt;
  logic [47:0]       rem_r, rem_nxt;

  logic [48:0] div_sh, div_dif;
  logic        div_ge;
  logic [35:0] sq_sh, sq_trial, sq_dif;
  logic        sq_ge;
  logic [63:0] mul_sum;

  always_comb begin
    div_sh   = {rem_r, x_r[63]};
    div_ge   = div_sh >= {1'b0, y_r};
    div_dif  = div_sh - {1'b0, y_r};
    sq_sh    = {rem_r[33:0], x_r[63:62]};
    sq_trial = {2'b00, acc_r[31:0], 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    sq_dif   = sq_sh - sq_trial;
    mul_sum  = acc_r + (y_r[0] ? x_r : 64'd0);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      op_nxt   = op;
      unique case (op)
        AOP_MUL: begin
          acc_nxt = '0;
          x_nxt   = 64'(opa[32:0]);
          y_nxt   = 48'(opb[32:0]);
          cnt_nxt = STEP_W'(MUL_STEPS - 1);
        end
        AOP_DIV: begin
          x_nxt   = opa;
          y_nxt   = opb;
          rem_nxt = '0;
          cnt_nxt = STEP_W'(DIV_STEPS - 1);
        end
        AOP_SQRT: begin
          x_nxt   = opa;
          acc_nxt = '0;
          rem_nxt = '0;
          cnt_nxt = STEP_W'(SQRT_STEPS - 1);
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end else if (busy_r) begin
      unique case (op_r)
        AOP_MUL: begin
          acc_nxt = mul_sum;
          x_nxt   = {x_r[62:0], 1'b0};
          y_nxt   = {1'b0, y_r[47:1]};
        end
        AOP_DIV: begin
          rem_nxt = div_ge ? div_dif[47:0] : div_sh[47:0];
          x_nxt   = {x_r[62:0], div_ge};
        end
        AOP_SQRT: begin
          rem_nxt = sq_ge ? 48'(sq_dif) : 48'(sq_sh);
          acc_nxt = {acc_r[62:0], sq_ge};
          x_nxt   = {x_r[61:0], 2'b00};
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    rem_r <= rem_nxt;
  end

  always_comb begin
    unique case (op_r)
      AOP_MUL:  result = acc_r;
      AOP_DIV:  result = x_r;
      AOP_SQRT: result = {32'd0, acc_r[31:0]};
      default:  result = acc_r;
    endcase
  end

  assign done = done_r;

endmodule

// File: rtl/core/vmpe_dp.sv
module vmpe_dp
  import vmpe_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic                    in_action,
  input  logic [COMP_W-1:0]       in_component,
  input  logic signed [SUM_W-1:0] in_sum_x,
  input  logic signed [SUM_W-1:0] in_sum_y,
  input  logic [CNT_W-1:0]        in_sample_count,
  input  logic [ANG_W-1:0]        in_load_mean,
  input  logic [KAP_W-1:0]        in_load_concentration,
  input  logic                    cfg_wr_en,
  input  logic [KAP_W-1:0]        cfg_wr_data,
  input  tbl_entry_t              tbl_rd,
  output tbl_wr_t                 tbl_wr,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [ANG_W-1:0]        out_mean_angle,
  output logic [KAP_W-1:0]        out_concentration,
  output logic                    out_estimate_valid,
  output logic                    out_kappa_capped
);

  logic              act_r;
  logic [COMP_W-1:0] comp_r;
  logic [32:0]       ax_r, ay_r;
  logic              nx_r, ny_r;
  logic [CNT_W-1:0]  n_r;
  logic [ANG_W-1:0]  lm_r;
  logic [KAP_W-1:0]  lc_r;
  logic              force_one_r;
  logic [64:0]       s_r;
  logic [31:0]       r_r;
  logic [23:0]       rho_r, r2_r;
  logic [49:0]       num_r;
  logic [31:0]       kappa_r;
  logic [47:0]       den_r;
  logic [30:0]       t_r, t2_r, at_r, ang_r;
  logic [31:0]       p_r;
  logic [KAP_W-1:0]  cap_r;

  logic             out_valid_r, out_valid_nxt;
  logic [ANG_W-1:0] out_mean_r;
  logic [KAP_W-1:0] out_conc_r;
  logic             out_ev_r, out_cap_r;

  logic [32:0] sx_u, sy_u, ax_in, ay_in, d_in;
  logic [31:0] d;
  logic        swap;
  logic [32:0] mn, mx;
  logic        p_neg;
  logic [31:0] p_abs;

  aop_t        aop;
  logic [63:0] opa;
  logic [47:0] opb;
  logic        a_done;
  logic [63:0] res;

  logic [31:0] term;
  logic [30:0] a1;
  logic [32:0] th;
  logic [33:0] th_rnd;
  logic [ANG_W-1:0] mean;
  logic             capped;
  logic [KAP_W-1:0] kap;
  logic [ANG_W-1:0] r_mean;
  logic [KAP_W-1:0] r_conc;
  logic             r_ev, r_cap;

  always_comb begin
    sx_u  = in_sum_x;
    sy_u  = in_sum_y;
    ax_in = sx_u[32] ? (~sx_u + 33'd1) : sx_u;
    ay_in = sy_u[32] ? (~sy_u + 33'd1) : sy_u;
    d_in  = 33'({in_sample_count, 16'd0});
    d     = {n_r, 16'd0};
    swap  = ay_r > ax_r;
    mn    = swap ? ax_r : ay_r;
    mx    = swap ? ay_r : ax_r;
    p_neg = p_r[31];
    p_abs = p_neg ? (~p_r + 32'd1) : p_r;
  end

  // operand select for the shared unit
  always_comb begin
    aop = AOP_MUL;
    opa = '0;
    opb = '0;
    unique case (cmd.uop)
      U_AXX: begin opa = 64'(ax_r); opb = 48'(ax_r); end
      U_AYY: begin opa = 64'(ay_r); opb = 48'(ay_r); end
      U_DD:  begin opa = 64'(d); opb = 48'(d); end
      U_SQRT: begin
        aop = AOP_SQRT;
        opa = s_r[63:0];
      end
      U_RHO: begin
        aop = AOP_DIV;
        opa = 64'({r_r, 24'd0});
        opb = 48'(d);
      end
      U_R2:  begin opa = 64'(rho_r); opb = 48'(rho_r); end
      U_LNUM: begin
        opa = 64'(rho_r);
        opb = 48'((26'd1 << 25) - 26'(r2_r));
      end
      U_LDIV: begin
        aop = AOP_DIV;
        opa = 64'(num_r);
        opb = 48'({(25'd1 << 24) - 25'(r2_r), 16'd0});
      end
      U_UDEN: begin
        opa = 64'(rho_r);
        opb = 48'((25'd1 << 24) - 25'(rho_r));
      end
      U_UDIV: begin
        aop = AOP_DIV;
        opa = 64'({25'(rho_r) + (25'd1 << 24), 32'd0});
        opb = den_r;
      end
      U_T: begin
        aop = AOP_DIV;
        opa = 64'({mn, 30'd0});
        opb = 48'(mx);
      end
      U_T2:   begin opa = 64'(t_r); opb = 48'(t_r); end
      U_HORN: begin opa = 64'(p_abs); opb = 48'(t2_r); end
      U_PT:   begin opa = 64'(p_abs); opb = 48'(t_r); end
      U_ANG:  begin opa = 64'(at_r); opb = 48'(TWO_OVER_PI_Q30); end
    endcase
  end

  vmpe_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start),
    .op     (aop),
    .opa    (opa),
    .opb    (opb),
    .done   (a_done),
    .result (res)
  );

  assign term = p_neg ? (32'd0 - res[61:30]) : res[61:30];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r       <= in_action;
      comp_r      <= in_component;
      ax_r        <= ax_in;
      ay_r        <= ay_in;
      nx_r        <= sx_u[32];
      ny_r        <= sy_u[32];
      n_r         <= in_sample_count;
      lm_r        <= in_load_mean;
      lc_r        <= in_load_concentration;
      force_one_r <= (ax_in >= d_in) || (ay_in >= d_in);
    end
    if (cmd.retire) begin
      unique case (cmd.uop)
        U_AXX:  s_r <= 65'(res);
        U_AYY:  s_r <= s_r + 65'(res);
        U_DD:   force_one_r <= s_r >= 65'(res);
        U_SQRT: r_r <= res[31:0];
        U_RHO:  rho_r <= res[23:0];
        U_R2:   r2_r <= res[47:24];
        U_LNUM: num_r <= res[49:0];
        U_LDIV: kappa_r <= res[31:0];
        U_UDEN: den_r <= {res[45:0], 2'b00};
        U_UDIV: kappa_r <= res[31:0];
        U_T:    t_r <= res[30:0];
        U_T2: begin
          t2_r <= res[60:30];
          p_r  <= atan_coef(3'd0);
        end
        U_HORN: p_r <= atan_coef(3'(cmd.horn_idx) + 3'd1) + term;
        U_PT:   at_r <= p_neg ? 31'd0 : res[60:30];
        U_ANG:  ang_r <= res[60:30];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // unfold the octant, then round to 16 bits of a turn
  always_comb begin
    if (swap) begin
      a1 = (ang_r >= 31'h4000_0000) ? 31'd0 : 31'h4000_0000 - ang_r;
    end else begin
      a1 = ang_r;
    end
    unique case ({nx_r, ny_r})
      2'b00: th = 33'(a1);
      2'b10: th = 33'h0_8000_0000 - 33'(a1);
      2'b11: th = 33'h0_8000_0000 + 33'(a1);
      2'b01: th = 33'h1_0000_0000 - 33'(a1);
    endcase
    th_rnd = 34'(th) + 34'h8000;
    mean   = th_rnd[31:16];
    capped = force_one_r || (kappa_r > 32'(cap_r));
    kap    = capped ? cap_r : kappa_r[KAP_W-1:0];
  end

  always_comb begin
    unique case (cmd.res)
      RES_LOAD: begin
        r_mean = lm_r;
        r_conc = lc_r;
        r_ev   = 1'b0;
        r_cap  = 1'b0;
      end
      RES_KEEP: begin
        r_mean = tbl_rd.mean;
        r_conc = tbl_rd.conc;
        r_ev   = 1'b0;
        r_cap  = 1'b0;
      end
      RES_EST: begin
        r_mean = mean;
        r_conc = kap;
        r_ev   = 1'b1;
        r_cap  = capped;
      end
      default: begin
        r_mean = lm_r;
        r_conc = lc_r;
        r_ev   = 1'b0;
        r_cap  = 1'b0;
      end
    endcase
    tbl_wr.en          = cmd.publish && (cmd.res == RES_LOAD || cmd.res == RES_EST);
    tbl_wr.comp        = comp_r;
    tbl_wr.entry.mean  = r_mean;
    tbl_wr.entry.conc  = r_conc;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.publish) begin
      out_mean_r <= r_mean;
      out_conc_r <= r_conc;
      out_ev_r   <= r_ev;
      out_cap_r  <= r_cap;
    end
  end

  always_comb begin
    stat.load       = act_r;
    stat.invalid    = (n_r == '0) || (ax_r == '0 && ay_r == '0);
    stat.force_one  = force_one_r;
    stat.lower      = (26'(rho_r) + {1'b0, rho_r, 1'b0}) < (26'd1 << 25);
    stat.arith_done = a_done;
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_mean_angle     = out_mean_r;
  assign out_concentration  = out_conc_r;
  assign out_estimate_valid = out_ev_r;
  assign out_kappa_capped   = out_cap_r;

endmodule

// File: rtl/core/vmpe_table.sv
module vmpe_table
  import vmpe_pkg::*;
#(
  parameter int COMPONENTS = COMPONENTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [COMP_W-1:0] rd_comp,
  output tbl_entry_t        rd_data,
  input  tbl_wr_t           wr,
  output logic              ready
);

  localparam int IDX_W = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

  tbl_entry_t mem [COMPONENTS];
  tbl_entry_t rd_data_r;

  logic             clearing_r, clearing_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             rd_in, wr_in;
  logic [IDX_W-1:0] ridx, widx;
  logic             we;
  logic [IDX_W-1:0] wa;
  tbl_entry_t       wd;

  always_comb begin
    rd_in = 32'(rd_comp) < COMPONENTS;
    wr_in = 32'(wr.comp) < COMPONENTS;
    ridx  = rd_in ? IDX_W'(rd_comp) : '0;
    widx  = wr_in ? IDX_W'(wr.comp) : '0;
    if (clearing_r) begin
      we = 1'b1;
      wa = clr_cnt_r;
      wd = '0;
    end else begin
      we = wr.en && wr_in;
      wa = widx;
      wd = wr.entry;
    end
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      if (clr_cnt_r == IDX_W'(COMPONENTS - 1)) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= rd_in ? mem[ridx] : '0;
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = !clearing_r;

endmodule

// File: rtl/core/vmpe_ctrl.sv
module vmpe_ctrl
  import vmpe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     tbl_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t     state_r, state_nxt;
  uop_t       uop_r, uop_nxt;
  logic [1:0] horn_r, horn_nxt;
  res_t       res_r, res_nxt;

  always_comb begin
    state_nxt = state_r;
    uop_nxt   = uop_r;
    horn_nxt  = horn_r;
    res_nxt   = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && tbl_ready) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        priority if (stat.load) begin
          res_nxt   = RES_LOAD;
          state_nxt = ST_DONE;
        end else if (stat.invalid) begin
          res_nxt   = RES_KEEP;
          state_nxt = ST_DONE;
        end else begin
          uop_nxt   = stat.force_one ? U_T : U_AXX;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (stat.arith_done) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        state_nxt = ST_ISSUE;
        unique case (uop_r)
          U_AXX:  uop_nxt = U_AYY;
          U_AYY:  uop_nxt = U_DD;
          U_DD:   uop_nxt = stat.force_one ? U_T : U_SQRT;
          U_SQRT: uop_nxt = U_RHO;
          U_RHO:  uop_nxt = stat.lower ? U_R2 : U_UDEN;
          U_R2:   uop_nxt = U_LNUM;
          U_LNUM: uop_nxt = U_LDIV;
          U_LDIV: uop_nxt = U_T;
          U_UDEN: uop_nxt = U_UDIV;
          U_UDIV: uop_nxt = U_T;
          U_T:    uop_nxt = U_T2;
          U_T2: begin
            uop_nxt  = U_HORN;
            horn_nxt = 2'd0;
          end
          U_HORN: begin
            horn_nxt = horn_r + 2'd1;
            uop_nxt  = (horn_r == 2'd3) ? U_PT : U_HORN;
          end
          U_PT:   uop_nxt = U_ANG;
          U_ANG: begin
            res_nxt   = RES_EST;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == ST_IDLE) && tbl_ready;
    cmd.capture  = in_ready && in_valid;
    cmd.start    = state_r == ST_ISSUE;
    cmd.retire   = (state_r == ST_WAIT) && stat.arith_done;
    cmd.uop      = uop_r;
    cmd.horn_idx = horn_r;
    cmd.publish  = (state_r == ST_DONE) && stat.out_free;
    cmd.res      = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      uop_r   <= U_AXX;
      horn_r  <= 2'd0;
      res_r   <= RES_LOAD;
    end else begin
      state_r <= state_nxt;
      uop_r   <= uop_nxt;
      horn_r  <= horn_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

// File: rtl/core/von_mises_parameter_estimator.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    action, component, sums, count, load values
// out      output     out_valid / out_ready  mean angle, concentration, flags
// cfg      input      cfg_wr_en              kappa_cap
//
// Loads and kept entries skip the arithmetic; estimates run each multiply, restoring
// divide and square root in sequence on the single shared unit, one item at a time.
// After reset the table clears every entry before in_ready rises.
// A result waits in the output register while the next item is taken in.
module von_mises_parameter_estimator
  import vmpe_pkg::*;
#(
  parameter int COMPONENTS = COMPONENTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_action,
  input  logic [COMP_W-1:0]       in_component,
  input  logic signed [SUM_W-1:0] in_sum_x,
  input  logic signed [SUM_W-1:0] in_sum_y,
  input  logic [CNT_W-1:0]        in_sample_count,
  input  logic [ANG_W-1:0]        in_load_mean,
  input  logic [KAP_W-1:0]        in_load_concentration,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ANG_W-1:0]        out_mean_angle,
  output logic [KAP_W-1:0]        out_concentration,
  output logic                    out_estimate_valid,
  output logic                    out_kappa_capped,
  input  logic                    cfg_wr_en,
  input  logic [KAP_W-1:0]        cfg_wr_data
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  tbl_entry_t tbl_rd;
  tbl_wr_t    tbl_wr;
  logic       tbl_ready;

  vmpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .tbl_ready (tbl_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  vmpe_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_action             (in_action),
    .in_component          (in_component),
    .in_sum_x              (in_sum_x),
    .in_sum_y              (in_sum_y),
    .in_sample_count       (in_sample_count),
    .in_load_mean          (in_load_mean),
    .in_load_concentration (in_load_concentration),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .tbl_rd                (tbl_rd),
    .tbl_wr                (tbl_wr),
    .out_ready             (out_ready),
    .out_valid             (out_valid),
    .out_mean_angle        (out_mean_angle),
    .out_concentration     (out_concentration),
    .out_estimate_valid    (out_estimate_valid),
    .out_kappa_capped      (out_kappa_capped)
  );

  vmpe_table #(
    .COMPONENTS (COMPONENTS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (cmd.capture),
    .rd_comp (in_component),
    .rd_data (tbl_rd),
    .wr      (tbl_wr),
    .ready   (tbl_ready)
  );

endmodule
